FILE: design/lb64d_pkg.sv
package lb64d_pkg;

   // Character codes of the lenient alphabet
   localparam logic [7:0] PAD_CHAR     = 8'h3D;  // '='
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;

   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_62         = 6'd62;
   localparam logic [5:0] SEXTET_63         = 6'd63;

   localparam int GROUP_BITS_W = 18;

   // Up to three decoded bytes from one character, first byte in bytes[0]
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            last;
   } bundle_type;

   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [5:0] v;
      logic [7:0] d;
      v = '0;
      d = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = c - CHAR_UPPER_A;
         v = d[5:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = c - CHAR_LOWER_A;
         v = d[5:0] + SEXTET_LOWER_BASE;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d = c - CHAR_DIGIT_0;
         v = d[5:0] + SEXTET_DIGIT_BASE;
      end else if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_DOT) begin
         v = SEXTET_62;
      end else if (c == CHAR_SLASH || c == CHAR_COMMA || c == CHAR_UNDER) begin
         v = SEXTET_63;
      end
      return v;
   endfunction

endpackage

FILE: design/lb64d_group.sv
module lb64d_group (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_char,
   input  logic                   req_final,
   input  logic                   slot_ok,
   output logic                   req_ready,
   output logic                   load,
   output lb64d_pkg::bundle_type  bundle
);

   logic [lb64d_pkg::GROUP_BITS_W-1:0] group_bits_ff, group_bits_in;
   logic [1:0]                         group_count_ff, group_count_in;
   logic                               third_pad_ff, third_pad_in;

   logic [5:0]                         sextet;
   logic                               is_pad;
   logic [lb64d_pkg::GROUP_BITS_W-1:0] placed;
   logic [lb64d_pkg::GROUP_BITS_W-1:0] tail_bits;
   logic [23:0]                        full_word;
   logic                               produces;
   logic                               accept;
   logic                               two_bytes;

   always_comb begin
      sextet    = lb64d_pkg::sextet_of(req_char);
      is_pad    = (req_char == lb64d_pkg::PAD_CHAR);
      full_word = {group_bits_ff[lb64d_pkg::GROUP_BITS_W-1:0], sextet};

      placed = group_bits_ff;
      case (group_count_ff)
         2'd0:    placed[17:12] = sextet;
         2'd1:    placed[11:6]  = sextet;
         2'd2:    placed[5:0]   = sextet;
         default: placed        = group_bits_ff;
      endcase

      // A character yields bytes when it completes a group or closes the text
      produces  = req_final || (group_count_ff == 2'd3);
      req_ready = slot_ok || !produces;
      accept    = req_valid && req_ready;
      load      = accept && produces;

      tail_bits = (group_count_ff == 2'd3) ? group_bits_ff : placed;
      two_bytes = ((group_count_ff == 2'd2) && !is_pad) ||
                  ((group_count_ff == 2'd3) && !third_pad_ff);

      bundle = '0;
      if ((group_count_ff == 2'd3) && (!req_final || !is_pad)) begin
         bundle.bytes[0] = full_word[23:16];
         bundle.bytes[1] = full_word[15:8];
         bundle.bytes[2] = full_word[7:0];
         bundle.count    = 2'd3;
         bundle.last     = req_final;
      end else begin
         // Short or padded final group: the fourth character adds nothing
         bundle.bytes[0] = tail_bits[17:10];
         bundle.bytes[1] = tail_bits[9:2];
         bundle.count    = two_bytes ? 2'd2 : 2'd1;
         bundle.last     = 1'b1;
      end

      group_bits_in  = group_bits_ff;
      group_count_in = group_count_ff;
      third_pad_in   = third_pad_ff;
      if (accept) begin
         if (produces) begin
            group_bits_in  = '0;
            group_count_in = '0;
            third_pad_in   = 1'b0;
         end else begin
            group_bits_in  = placed;
            group_count_in = group_count_ff + 2'd1;
            if (group_count_ff == 2'd2) begin
               third_pad_in = is_pad;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_bits_ff  <= '0;
         group_count_ff <= '0;
         third_pad_ff   <= 1'b0;
      end else begin
         group_bits_ff  <= group_bits_in;
         group_count_ff <= group_count_in;
         third_pad_ff   <= third_pad_in;
      end
   end

endmodule

FILE: design/lb64d_serial.sv
module lb64d_serial (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  lb64d_pkg::bundle_type  bundle,
   output logic                   slot_ok,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);

   logic [2:0][7:0] bun_bytes_ff, bun_bytes_in;
   logic [1:0]      bun_cnt_ff, bun_cnt_in;
   logic            bun_last_ff, bun_last_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            out_free;
   logic            move;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      move     = out_free && (bun_cnt_ff != 2'd0);
      slot_ok  = (bun_cnt_ff == 2'd0) || ((bun_cnt_ff == 2'd1) && out_free);

      bun_bytes_in = bun_bytes_ff;
      bun_cnt_in   = bun_cnt_ff;
      bun_last_in  = bun_last_ff;
      if (load) begin
         bun_bytes_in = bundle.bytes;
         bun_cnt_in   = bundle.count;
         bun_last_in  = bundle.last;
      end else if (move) begin
         // advance the next byte to the head
         bun_bytes_in[0] = bun_bytes_ff[1];
         bun_bytes_in[1] = bun_bytes_ff[2];
         bun_cnt_in      = bun_cnt_ff - 2'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = bun_bytes_ff[0];
         rsp_last_in  = bun_last_ff && (bun_cnt_ff == 2'd1);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bun_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bun_cnt_ff   <= bun_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bun_bytes_ff <= bun_bytes_in;
      bun_last_ff  <= bun_last_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: design/lenient_base64_decoder.sv
// Lenient base64 decoder.
// Input stream req_*: one text character per transaction in req_tdata, with
// req_tlast marking the last character of the text. Output stream rsp_*: one
// decoded byte per transaction, rsp_tlast on the last byte of the text.
// Every fourth character of a group, and the closing character, hands up to
// three bytes to a small byte buffer; the buffer feeds a registered output.
// Once the character that completes a group is taken, its first byte passes the
// byte buffer and then the output register before it shows on rsp_tvalid.
// No text yields more bytes than it has characters. A character that only adds
// to a group is taken while earlier bytes still drain from the buffer; one that
// yields bytes waits only while the buffer holds two or more bytes, or one byte
// that the stalled output cannot take. Other characters are never held off.
// Reset clears the group state, the buffer and the output valid.
// While rsp_tready is low the output byte holds, the buffer fills, and then
// req_tready falls for characters that would produce bytes; characters that
// only add to a group keep being taken.
module lenient_base64_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_char
   input  logic       req_tlast,   // final_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic       rsp_tlast    // end_of_data
);

   lb64d_pkg::bundle_type bundle;
   logic                  load;
   logic                  slot_ok;

   lb64d_group u_group (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_char  (req_tdata),
      .req_final (req_tlast),
      .slot_ok   (slot_ok),
      .req_ready (req_tready),
      .load      (load),
      .bundle    (bundle)
   );

   lb64d_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .bundle     (bundle),
      .slot_ok    (slot_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: design/lb64d_checker.sv
module lb64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // no output straight after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // hold a stalled output transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output changed");

   // a closing character is always followed by a byte waiting on the output
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> ##1 rsp_tvalid)
      else $error("no output after closing character");

endmodule

bind lenient_base64_decoder lb64d_checker u_lb64d_checker (.*);

FILE: tb/decoded_byte_checker.sv
module decoded_byte_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_char
   input  logic       req_tlast,   // final_char
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] data_byte
   input  logic       rsp_tlast,   // end_of_data
   output int         failures,
   output int         bytes_awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } decoded_byte_type;

   decoded_byte_type byte_queue[$];

   // group being collected
   logic [17:0] sextet_acc;
   logic [1:0]  chars_held;
   logic        third_was_pad;

   function automatic logic [5:0] char_sextet(input logic [7:0] ch);
      logic [7:0] offset;
      offset = 8'd0;
      if (ch >= lb64d_pkg::CHAR_UPPER_A && ch <= lb64d_pkg::CHAR_UPPER_Z)
         offset = ch - lb64d_pkg::CHAR_UPPER_A;
      else if (ch >= lb64d_pkg::CHAR_LOWER_A && ch <= lb64d_pkg::CHAR_LOWER_Z)
         offset = ch - lb64d_pkg::CHAR_LOWER_A + 8'd26;
      else if (ch >= lb64d_pkg::CHAR_DIGIT_0 && ch <= lb64d_pkg::CHAR_DIGIT_9)
         offset = ch - lb64d_pkg::CHAR_DIGIT_0 + 8'd52;
      else if (ch == lb64d_pkg::CHAR_PLUS || ch == lb64d_pkg::CHAR_MINUS ||
               ch == lb64d_pkg::CHAR_DOT)
         offset = 8'd62;
      else if (ch == lb64d_pkg::CHAR_SLASH || ch == lb64d_pkg::CHAR_COMMA ||
               ch == lb64d_pkg::CHAR_UNDER)
         offset = 8'd63;
      return offset[5:0];
   endfunction

   function automatic decoded_byte_type mk(input logic [7:0] b, input logic last);
      decoded_byte_type d;
      d.data_byte   = b;
      d.end_of_data = last;
      return d;
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic last);
      byte_queue = {byte_queue, mk(b, last)};
   endtask

   task automatic decode_char(input logic [7:0] ch, input logic closing);
      logic [5:0]  sx;
      logic [17:0] word18;
      logic [23:0] word24;
      logic        is_pad;
      sx     = char_sextet(ch);
      is_pad = (ch == lb64d_pkg::PAD_CHAR);
      word18 = sextet_acc;
      word24 = {sextet_acc, sx};
      if (!closing && chars_held != 2'd3) begin
         case (chars_held)
            2'd0: sextet_acc[17:12] = sx;
            2'd1: sextet_acc[11:6]  = sx;
            default: begin
               sextet_acc[5:0] = sx;
               third_was_pad   = is_pad;
            end
         endcase
         chars_held = chars_held + 2'd1;
         return;
      end
      if (!closing || (chars_held == 2'd3 && !is_pad)) begin
         put_byte(word24[23:16], 1'b0);
         put_byte(word24[15:8], 1'b0);
         put_byte(word24[7:0], closing);
      end else begin
         case (chars_held)
            2'd0: put_byte({sx, 2'b00}, 1'b1);
            2'd1: begin
               word18[11:6] = sx;
               put_byte(word18[17:10], 1'b1);
            end
            2'd2: begin
               word18[5:0] = sx;
               if (is_pad) begin
                  put_byte(word18[17:10], 1'b1);
               end else begin
                  put_byte(word18[17:10], 1'b0);
                  put_byte(word18[9:2], 1'b1);
               end
            end
            default: begin
               // closing '=' in fourth place adds nothing of its own
               if (third_was_pad) begin
                  put_byte(word18[17:10], 1'b1);
               end else begin
                  put_byte(word18[17:10], 1'b0);
                  put_byte(word18[9:2], 1'b1);
               end
            end
         endcase
      end
      sextet_acc    = '0;
      chars_held    = '0;
      third_was_pad = 1'b0;
   endtask

   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         byte_queue.delete();
         sextet_acc    = '0;
         chars_held    = '0;
         third_was_pad = 1'b0;
         failures      = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (byte_queue.size() == 0) begin
               $error("data_byte %02h arrived with nothing expected", rsp_tdata);
               failures++;
            end else begin
               want = byte_queue.pop_front();
               if (rsp_tdata !== want.data_byte) begin
                  $error("data_byte: expected %02h, got %02h", want.data_byte, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== want.end_of_data) begin
                  $error("end_of_data: expected %0b, got %0b", want.end_of_data,
                         rsp_tlast);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready)
            decode_char(req_tdata, req_tlast);
      end
      bytes_awaited = byte_queue.size();
   end

endmodule

FILE: tb/lenient_base64_decoder_tb.sv
module lenient_base64_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_CHARS  = 130;
   localparam int HOLD_CYCLES   = 80;
   localparam int STALL_LIMIT   = 2000;
   localparam string ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+-./,_";

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] text_char
   logic       req_tlast;   // final_char
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] data_byte
   logic       rsp_tlast;   // end_of_data

   int   failures;
   int   bytes_awaited;
   int   chars_sent;
   logic idling;
   logic hold_req;

   lenient_base64_decoder DUT (.*);

   decoded_byte_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] pick_text_char();
      int r;
      r = $urandom_range(99);
      if (r < 65)
         return ALPHABET[$urandom_range(ALPHABET.len() - 1)];
      else if (r < 75)
         return lb64d_pkg::PAD_CHAR;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_char(input logic [7:0] ch, input logic closing);
      while (idling && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= closing;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic closing);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], closing && i == s.len() - 1);
   endtask

   task automatic send_random_text();
      logic [7:0] txt[$];
      int         len;
      len = $urandom_range(1, 14);
      for (int i = 0; i < len; i++)
         txt = {txt, pick_text_char()};
      // well-formed padding on a share of the texts
      if ($urandom_range(99) < 35) begin
         if (len % 4 == 2) begin
            txt = {txt, lb64d_pkg::PAD_CHAR};
            txt = {txt, lb64d_pkg::PAD_CHAR};
         end else if (len % 4 == 3) begin
            txt = {txt, lb64d_pkg::PAD_CHAR};
         end
      end
      foreach (txt[i])
         send_char(txt[i], i == txt.size() - 1);
   endtask

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= (!idling || $urandom_range(99) >= 36);
      end
   end

   // watchdog: give up after a long run of cycles with no transaction
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      bit pressure_done;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      reset         = 1'b1;
      idling        = 1'b1;
      hold_req      = 1'b0;
      chars_sent    = 0;
      pressure_done = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every special character, padding and an unknown byte mid-text
      send_text("+-./", 1'b0);
      send_char(lb64d_pkg::PAD_CHAR, 1'b0);
      send_text(",_", 1'b0);
      send_char(8'hFF, 1'b0);
      // full closing group without padding
      send_text("Az9", 1'b0);
      send_char(8'h00, 1'b1);
      // short closing groups, padded and not
      send_text("TQ==", 1'b1);
      send_text("TWE=", 1'b1);
      send_text("T", 1'b1);
      send_text("TW=", 1'b1);
      send_text("TWE", 1'b1);
      send_text("TW", 1'b1);

      while (chars_sent < RANDOM_CHARS) begin
         idling = !(chars_sent >= 45 && chars_sent < 85);
         if (!pressure_done && chars_sent >= 90) begin
            // stall the output and keep offering a long text
            pressure_done = 1'b1;
            idling        = 1'b0;
            hold_req      = 1'b1;
            for (int i = 0; i < 24; i++)
               send_char(ALPHABET[$urandom_range(ALPHABET.len() - 1)], i == 23);
            idling = 1'b1;
         end else begin
            send_random_text();
         end
      end
      req_tvalid <= 1'b0;

      while (bytes_awaited != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
